// ----- rtl/tfc_pkg.sv -----
// shared types, codes and helper functions of the text frame checker
`default_nettype none

package tfc_pkg;

   // parse phases
   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_XNUM   = 3'd1;
   localparam logic [2:0] PH_YNUM   = 3'd2;
   localparam logic [2:0] PH_HEX    = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   // error codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_PARSE = 2'd1;
   localparam logic [1:0] ERR_CRC   = 2'd2;
   localparam logic [1:0] ERR_SHORT = 2'd3;

   // characters
   localparam logic [7:0] CHAR_HEADER = 8'h58;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;

   // crc-16/ccitt-false
   localparam logic [15:0] CRC_SEED = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam int HOLD_DEPTH = 4;

   // per-frame parse and crc state
   typedef struct packed {
      logic [2:0]  phase;
      logic        failed;
      logic        digit;
      logic        sign;
      logic        minus;
      logic [31:0] first;
      logic [31:0] second;
      logic [31:0] hexv;
      logic [15:0] crc;
      logic [2:0]  count;
   } state_type;

   localparam state_type ST_CLEAR = '{
      phase:  PH_HEADER,
      failed: 1'b0,
      digit:  1'b0,
      sign:   1'b0,
      minus:  1'b0,
      first:  32'd0,
      second: 32'd0,
      hexv:   32'd0,
      crc:    CRC_SEED,
      count:  3'd0
   };

   // frame snapshot taken at the last item, finished in the result stage
   typedef struct packed {
      logic [2:0]  phase;
      logic        failed;
      logic        digit;
      logic        minus;
      logic [31:0] first;
      logic [31:0] second;
      logic [15:0] hex_lo;
      logic [15:0] crc;
      logic        short_frame;
   } frame_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   // {valid, nibble}
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61) && (c <= 8'h66)) begin
         r = {1'b1, 4'(c[3:0] + 4'd9)};
      end else if ((c >= 8'h41) && (c <= 8'h46)) begin
         r = {1'b1, 4'(c[3:0] + 4'd9)};
      end
      return r;
   endfunction

   // one byte through the crc, msb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (r[15]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/text_frame_checker.sv -----
// text frame checker: parses "X <int> <int> <hex>" frames and checks their crc
`default_nettype none

// Takes one character per clock on the req channel (tlast marks the final
// character of a frame) and gives one result item per frame on the rsp
// channel. The block sustains one character per cycle while the input is not
// stalled: the byte-wide crc step, the decimal multiply-by-ten accumulate and
// the hex shift all settle combinationally between the req handshake and the
// state registers. The result of a frame is captured in a snapshot register
// at the final character and moves on into the result registers that drive
// rsp once they are free. While a result waits on rsp, characters keep flowing
// until the next frame finishes and fills the snapshot; from then on every
// character stalls until rsp takes the waiting result. No clearing pass is
// needed after reset.
module text_frame_checker
   import tfc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_in
   input  wire logic        req_tlast,   // end_of_frame
   // result channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,   // [31:0] acc_x, [63:32] acc_y
   output      logic [2:0]  rsp_tuser    // [0] frame_ok, [2:1] error_kind
);

   // parse state and hold line
   state_type   st_ff, st_in, st_step;
   logic [7:0]  held_ff [HOLD_DEPTH];
   logic [7:0]  held_in [HOLD_DEPTH];

   // snapshot stage
   frame_type   snap_ff, snap_in;
   logic        snap_valid_ff, snap_valid_in;

   // result stage
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] acc_x_ff, acc_x_in;
   logic [31:0] acc_y_ff, acc_y_in;
   logic [1:0]  err_ff, err_in;

   // datapath helpers
   logic        accept;
   logic        rsp_free;
   logic        snap_move;
   logic [7:0]  c;
   logic        c_ws;
   logic        c_dec;
   logic        c_sign;
   logic [4:0]  c_hex;
   logic [31:0] cur;
   logic [31:0] cur_next;
   logic [31:0] cur_signed;
   logic [35:0] dec_m;
   logic [35:0] dec_lim;

   // finishing logic
   logic        fin_dec;
   logic        fin_hex;
   logic [2:0]  phase_f;
   logic        ok_f;
   logic [31:0] first_f;
   logic [31:0] second_f;

   // handshake: the result register frees the snapshot, the snapshot frees the input
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign snap_move  = snap_valid_ff && rsp_free;
   assign req_tready = !snap_valid_ff || rsp_free;
   assign accept     = req_tvalid && req_tready;

   assign c      = req_tdata;
   assign c_ws   = is_space(c);
   assign c_dec  = is_dec(c);
   assign c_sign = (c == CHAR_PLUS) || (c == CHAR_MINUS);
   assign c_hex  = hex_nibble(c);

   // current decimal token and its next digit
   assign cur        = (st_ff.phase == PH_XNUM) ? st_ff.first : st_ff.second;
   assign cur_signed = st_ff.minus ? (32'd0 - cur) : cur;
   assign dec_m      = ({4'd0, cur} << 3) + ({4'd0, cur} << 1) + {32'd0, c[3:0]};
   assign dec_lim    = st_ff.minus ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;

   // one character through hold line, crc and parser
   always_comb begin
      st_step  = st_ff;
      cur_next = cur;
      held_in  = held_ff;

      // hold line keeps the last four characters out of the crc
      if (st_ff.count == 3'(HOLD_DEPTH)) begin
         st_step.crc = crc_byte(st_ff.crc, held_ff[0]);
         for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
            held_in[i] = held_ff[i + 1];
         end
         held_in[HOLD_DEPTH - 1] = c;
      end else begin
         held_in[st_ff.count[1:0]] = c;
         st_step.count = st_ff.count + 3'd1;
      end

      if (!st_ff.failed && (st_ff.phase != PH_DONE)) begin
         unique case (st_ff.phase) inside
            PH_HEADER: begin
               if (!c_ws) begin
                  if (c == CHAR_HEADER) begin
                     st_step.phase = PH_XNUM;
                  end else begin
                     st_step.failed = 1'b1;
                  end
               end
            end
            PH_XNUM, PH_YNUM: begin
               if (!(st_ff.sign || st_ff.digit) && c_ws) begin
                  // leading whitespace
               end else if (!(st_ff.sign || st_ff.digit) && c_sign) begin
                  st_step.sign  = 1'b1;
                  st_step.minus = (c == CHAR_MINUS);
               end else if (c_dec) begin
                  if (dec_m > dec_lim) begin
                     st_step.failed = 1'b1;
                     cur_next       = 32'd0;
                  end else begin
                     cur_next      = dec_m[31:0];
                     st_step.digit = 1'b1;
                  end
               end else if (st_ff.digit) begin
                  // token ends, the character opens the next token
                  cur_next      = cur_signed;
                  st_step.digit = 1'b0;
                  st_step.sign  = 1'b0;
                  st_step.minus = 1'b0;
                  st_step.phase = st_ff.phase + 3'd1;
                  if (st_ff.phase == PH_XNUM) begin
                     if (c_sign) begin
                        st_step.sign  = 1'b1;
                        st_step.minus = (c == CHAR_MINUS);
                     end else if (!c_ws) begin
                        st_step.failed = 1'b1;
                     end
                  end else begin
                     if (c_hex[4]) begin
                        st_step.hexv  = {28'd0, c_hex[3:0]};
                        st_step.digit = 1'b1;
                     end else if (!c_ws) begin
                        st_step.failed = 1'b1;
                     end
                  end
               end else begin
                  st_step.failed = 1'b1;
                  cur_next       = 32'd0;
               end
            end
            PH_HEX: begin
               if (!st_ff.digit && c_ws) begin
                  // leading whitespace
               end else if (c_hex[4]) begin
                  if (st_ff.hexv[31:28] != 4'd0) begin
                     st_step.failed = 1'b1;
                  end else begin
                     st_step.hexv  = {st_ff.hexv[27:0], c_hex[3:0]};
                     st_step.digit = 1'b1;
                  end
               end else if (st_ff.digit) begin
                  st_step.phase = PH_DONE;
               end else begin
                  st_step.failed = 1'b1;
               end
            end
            default: begin
            end
         endcase

         if (st_ff.phase == PH_XNUM) begin
            st_step.first = cur_next;
         end else if (st_ff.phase == PH_YNUM) begin
            st_step.second = cur_next;
         end
      end
   end

   // state update: a final character returns everything to a fresh frame
   always_comb begin
      st_in = st_ff;
      if (accept) begin
         st_in = req_tlast ? ST_CLEAR : st_step;
      end
   end

   // snapshot of the frame at its final character
   always_comb begin
      snap_in             = snap_ff;
      snap_valid_in       = snap_valid_ff;
      if (snap_move) begin
         snap_valid_in = 1'b0;
      end
      if (accept && req_tlast) begin
         snap_valid_in       = 1'b1;
         snap_in.phase       = st_step.phase;
         snap_in.failed      = st_step.failed;
         snap_in.digit       = st_step.digit;
         snap_in.minus       = st_step.minus;
         snap_in.first       = st_step.first;
         snap_in.second      = st_step.second;
         snap_in.hex_lo      = st_step.hexv[15:0];
         snap_in.crc         = st_step.crc;
         snap_in.short_frame = (st_step.count != 3'(HOLD_DEPTH));
      end
   end

   // close an open token at the end of the frame and grade it
   always_comb begin
      fin_dec = !snap_ff.failed && snap_ff.digit &&
                ((snap_ff.phase == PH_XNUM) || (snap_ff.phase == PH_YNUM));
      fin_hex = !snap_ff.failed && snap_ff.digit && (snap_ff.phase == PH_HEX);
      if (fin_dec) begin
         phase_f = snap_ff.phase + 3'd1;
      end else if (fin_hex) begin
         phase_f = PH_DONE;
      end else begin
         phase_f = snap_ff.phase;
      end
      ok_f = !snap_ff.failed && (phase_f == PH_DONE);

      first_f  = snap_ff.first;
      second_f = snap_ff.second;
      if (fin_dec && snap_ff.minus) begin
         if (snap_ff.phase == PH_XNUM) begin
            first_f = 32'd0 - snap_ff.first;
         end else begin
            second_f = 32'd0 - snap_ff.second;
         end
      end

      if (snap_ff.short_frame) begin
         err_in = ERR_SHORT;
      end else if (!ok_f) begin
         err_in = ERR_PARSE;
      end else if (snap_ff.hex_lo != snap_ff.crc) begin
         err_in = ERR_CRC;
      end else begin
         err_in = ERR_NONE;
      end
      acc_x_in = (phase_f > PH_XNUM) ? first_f : 32'd0;
      acc_y_in = (phase_f > PH_YNUM) ? second_f : 32'd0;

      if (snap_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_CLEAR;
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         st_ff         <= st_in;
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
      snap_ff <= snap_in;
      if (snap_move) begin
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
         err_ff   <= err_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {acc_y_ff, acc_x_ff};
   assign rsp_tuser  = {err_ff, (err_ff == ERR_NONE)};

`ifndef SYNTHESIS
   // a final character always lands in the snapshot
   assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> snap_valid_ff)
      else $error("final item not captured in snapshot");

   // a final character leaves a fresh frame behind
   assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> (st_ff.phase == PH_HEADER) && (st_ff.count == 3'd0)
                              && !st_ff.failed && (st_ff.crc == CRC_SEED))
      else $error("frame state not cleared after final item");

   // the crc only moves once the hold line is full
   assert property (@(posedge clock) disable iff (reset)
      (st_ff.count != 3'(HOLD_DEPTH)) |-> (st_ff.crc == CRC_SEED))
      else $error("crc advanced before hold line filled");

   // hold line fill count never passes its depth
   assert property (@(posedge clock) disable iff (reset)
      st_ff.count <= 3'(HOLD_DEPTH))
      else $error("hold line count out of range");

   // the snapshot never gets overwritten while it still waits
   assert property (@(posedge clock) disable iff (reset)
      snap_valid_ff && !rsp_free |-> !accept)
      else $error("input taken while snapshot blocked");
`endif

endmodule

`default_nettype wire
